// ===== hdl/safk_pkg.sv =====
// Shared types, constants and fixed-point helpers for the six-axis forward kinematics block.
// No dependencies.
package safk_pkg;

    localparam int AngW   = 26;
    localparam int LenW   = 30;
    localparam int OutW   = 32;
    localparam int TrigW  = 32;   // Q30 signed trig / rotation value, headroom for sums
    localparam int NumJ   = 6;

    localparam logic signed [26:0] Deg360 = 27'sd23592960;
    localparam logic [24:0] Deg90 = 25'd5898240;
    localparam logic [24:0] Deg45 = 25'd2949120;
    localparam logic [34:0] Krad  = 35'd19190098069;
    localparam logic [32:0] Q32One = 33'h1_0000_0000;
    localparam logic signed [63:0] RotLim = 64'sd1073741824;
    localparam logic signed [63:0] PosLim = 64'sd1342177280;

    localparam int SinSteps = 6;
    localparam int CosSteps = 7;

    // register indexes
    localparam logic [2:0] RegA1 = 3'd0;
    localparam logic [2:0] RegA2 = 3'd1;
    localparam logic [2:0] RegA3 = 3'd2;
    localparam logic [2:0] RegD4 = 3'd3;
    localparam logic [2:0] RegD1 = 3'd4;

    typedef logic signed [TrigW-1:0] t_trig;
    typedef logic signed [63:0] t_wide;

    typedef struct packed {
        t_trig sn;
        t_trig cs;
    } t_sc;

    function automatic logic [7:0] sin_div(input int i);
        case (i)
            0: sin_div = 8'd156;
            1: sin_div = 8'd110;
            2: sin_div = 8'd72;
            3: sin_div = 8'd42;
            4: sin_div = 8'd20;
            default: sin_div = 8'd6;
        endcase
    endfunction

    function automatic logic [7:0] cos_div(input int i);
        case (i)
            0: cos_div = 8'd182;
            1: cos_div = 8'd132;
            2: cos_div = 8'd90;
            3: cos_div = 8'd56;
            4: cos_div = 8'd30;
            5: cos_div = 8'd12;
            default: cos_div = 8'd2;
        endcase
    endfunction

    // ceiling log2 of a series divisor
    function automatic int div_log(input logic [7:0] n);
        int l;
        l = 0;
        while ((1 << l) < int'(n)) l++;
        return l;
    endfunction

    // ceil(2^(32+l) / n): floor divide of any 32-bit word by n is (y * rcp) >> (32+l)
    function automatic logic [32:0] div_rcp(input logic [7:0] n);
        logic [63:0] num;
        num = 64'd1 << (32 + div_log(n));
        return 33'((num + 64'(n) - 64'd1) / 64'(n));
    endfunction

    // rounded product / 2^30, ties away from zero
    function automatic t_wide mulq(input t_wide a, input t_wide b);
        t_wide p;
        logic [63:0] m;
        begin
            p = a * b;
            m = p[63] ? (64'd0 - 64'(p)) : 64'(p);
            m = (m + (64'd1 << 29)) >> 30;
            mulq = p[63] ? -t_wide'(m) : t_wide'(m);
        end
    endfunction

    function automatic t_wide clampv(input t_wide v, input t_wide lim);
        if (v > lim) clampv = lim;
        else if (v < -lim) clampv = -lim;
        else clampv = v;
    endfunction

endpackage

// ===== hdl/safk_trig_lane.sv =====
// One sine/cosine lane: angle reduction, pipelined Horner series, quadrant mapping.
// Depends on safk_pkg.
module safk_trig_lane (
    input  logic                       i_clk,
    input  logic [safk_pkg::AngW-1:0]  i_angle,
    output safk_pkg::t_sc              o_sc
);
    import safk_pkg::*;

    localparam int NSt = CosSteps;

    // stage 0: reduce and scale to radians
    logic signed [26:0] a_s, a_p1, a_mod;
    logic [24:0] a_pos, rr, rr2;
    logic [1:0] quad;
    logic swp;
    always_comb begin
        a_s = 27'(signed'(i_angle));
        a_p1 = a_s + Deg360;
        // the field spans less than two turns either way
        if (a_s >= Deg360) a_mod = a_s - Deg360;
        else if (a_s >= 27'sd0) a_mod = a_s;
        else if (a_p1 >= 27'sd0) a_mod = a_p1;
        else a_mod = a_p1 + Deg360;
        a_pos = a_mod[24:0];
        if (a_pos >= 25'(3 * 5898240)) begin
            quad = 2'd3; rr = a_pos - 25'(3 * 5898240);
        end else if (a_pos >= 25'(2 * 5898240)) begin
            quad = 2'd2; rr = a_pos - 25'(2 * 5898240);
        end else if (a_pos >= Deg90) begin
            quad = 2'd1; rr = a_pos - Deg90;
        end else begin
            quad = 2'd0; rr = a_pos;
        end
        swp = rr > Deg45;
        rr2 = swp ? Deg90 - rr : rr;
    end

    logic [59:0] r_xp;
    logic [1:0] r_q0;
    logic r_sw0;
    always_ff @(posedge i_clk) begin
        r_xp  <= 60'(rr2) * 60'(Krad);
        r_q0  <= quad;
        r_sw0 <= swp;
    end

    logic [31:0] x0;
    assign x0 = 32'((r_xp + 60'(1 << 23)) >> 24);

    // Horner chain, sine and cosine side by side, one step per two stages
    logic [32:0] r_ts [NSt+1];
    logic [32:0] r_tc [NSt+1];
    logic [31:0] r_xs [NSt+1];
    logic [31:0] r_x2s [NSt+1];
    logic [1:0] r_qs [NSt+1];
    logic r_sws [NSt+1];

    always_ff @(posedge i_clk) begin
        r_ts[0]  <= Q32One;
        r_tc[0]  <= Q32One;
        r_xs[0]  <= x0;
        r_x2s[0] <= 32'((64'(x0) * 64'(x0)) >> 32);
        r_qs[0]  <= r_q0;
        r_sws[0] <= r_sw0;
    end

    for (genvar g = 0; g < NSt; g++) begin : g_step
        localparam int SSh = 32 + div_log(sin_div(g));
        localparam logic [32:0] SRcp = div_rcp(sin_div(g));
        localparam int CSh = 32 + div_log(cos_div(g));
        localparam logic [32:0] CRcp = div_rcp(cos_div(g));
        logic [31:0] r_ys, r_yc, r_xm, r_x2m;
        logic [32:0] r_tsm;
        logic [1:0] r_qm;
        logic r_swm;
        logic [64:0] qs, qc;
        logic [32:0] ns, nc;
        // first half: scale the running term by x^2
        always_ff @(posedge i_clk) begin
            r_ys  <= 32'((65'(r_x2s[g]) * 65'(r_ts[g])) >> 32);
            r_yc  <= 32'((65'(r_x2s[g]) * 65'(r_tc[g])) >> 32);
            r_tsm <= r_ts[g];
            r_xm  <= r_xs[g];
            r_x2m <= r_x2s[g];
            r_qm  <= r_qs[g];
            r_swm <= r_sws[g];
        end
        // second half: divide by the series constant through its reciprocal
        always_comb begin
            qs = (65'(r_ys) * 65'(SRcp)) >> SSh;
            qc = (65'(r_yc) * 65'(CRcp)) >> CSh;
            ns = (g < SinSteps) ? Q32One - 33'(qs) : r_tsm;
            nc = Q32One - 33'(qc);
        end
        always_ff @(posedge i_clk) begin
            r_ts[g+1]  <= ns;
            r_tc[g+1]  <= nc;
            r_xs[g+1]  <= r_xm;
            r_x2s[g+1] <= r_x2m;
            r_qs[g+1]  <= r_qm;
            r_sws[g+1] <= r_swm;
        end
    end

    logic [63:0] svp;
    t_trig s0, c0, s1, c1;
    always_comb begin
        svp = 64'((65'(r_xs[NSt]) * 65'(r_ts[NSt])) >> 32);
        s0 = t_trig'((svp + 64'd2) >> 2);
        c0 = t_trig'((r_tc[NSt] + 33'd2) >> 2);
        s1 = r_sws[NSt] ? c0 : s0;
        c1 = r_sws[NSt] ? s0 : c0;
    end

    always_ff @(posedge i_clk) begin
        case (r_qs[NSt])
            2'd0: begin o_sc.sn <= s1;  o_sc.cs <= c1;  end
            2'd1: begin o_sc.sn <= c1;  o_sc.cs <= -s1; end
            2'd2: begin o_sc.sn <= -s1; o_sc.cs <= -c1; end
            default: begin o_sc.sn <= -c1; o_sc.cs <= s1; end
        endcase
    end
endmodule

// ===== hdl/safk_merge.sv =====
// Merge stage: combines the six lanes' sines and cosines into the pose, pipelined.
// Depends on safk_pkg.
module safk_merge (
    input  logic                                i_clk,
    input  safk_pkg::t_sc                       i_sc [safk_pkg::NumJ],
    input  logic signed [safk_pkg::LenW-1:0]    i_a1,
    input  logic signed [safk_pkg::LenW-1:0]    i_a2,
    input  logic signed [safk_pkg::LenW-1:0]    i_a3,
    input  logic signed [safk_pkg::LenW-1:0]    i_d4,
    input  logic signed [safk_pkg::LenW-1:0]    i_d1,
    output logic signed [safk_pkg::OutW-1:0]    o_res [12]
);
    import safk_pkg::*;

    t_wide s[NumJ], c[NumJ];
    always_comb begin
        for (int i = 0; i < NumJ; i++) begin
            s[i] = t_wide'(i_sc[i].sn);
            c[i] = t_wide'(i_sc[i].cs);
        end
    end

    // stage A
    t_wide r_c23, r_s23, r_s[NumJ], r_c[NumJ], r_a2c1, r_a2s1;
    always_ff @(posedge i_clk) begin
        r_c23 <= mulq(c[1], c[2]) - mulq(s[1], s[2]);
        r_s23 <= mulq(c[1], s[2]) + mulq(s[1], c[2]);
        r_a2c1 <= mulq(t_wide'(i_a2), c[1]);
        r_a2s1 <= mulq(t_wide'(i_a2), s[1]);
        for (int i = 0; i < NumJ; i++) begin
            r_s[i] <= s[i];
            r_c[i] <= c[i];
        end
    end

    // stage B
    t_wide r_u, r_v, r_cs23, r_ss23, r_c3s23, r_c3c4, r_g, r_reach, r_z;
    t_wide r_bc23, r_bs23, r_bs[NumJ], r_bc[NumJ];
    always_ff @(posedge i_clk) begin
        r_u     <= mulq(r_c[0], r_c23);
        r_v     <= mulq(r_s[0], r_c23);
        r_cs23  <= mulq(r_c[0], r_s23);
        r_ss23  <= mulq(r_s[0], r_s23);
        r_c3s23 <= mulq(r_c[3], r_s23);
        r_c3c4  <= mulq(r_c[3], r_c[4]);
        r_g     <= mulq(r_s[3], r_s23);
        r_reach <= t_wide'(i_a1) + r_a2c1 + mulq(t_wide'(i_a3), r_c23)
                   - mulq(t_wide'(i_d4), r_s23);
        r_z     <= t_wide'(i_d1) - mulq(t_wide'(i_d4), r_c23) - r_a2s1
                   - mulq(t_wide'(i_a3), r_s23);
        r_bc23 <= r_c23;
        r_bs23 <= r_s23;
        for (int i = 0; i < NumJ; i++) begin
            r_bs[i] <= r_s[i];
            r_bc[i] <= r_c[i];
        end
    end

    // stage C
    t_wide r_A, r_B, r_C, r_D, r_F, r_G, r_cs23c, r_ss23c, r_c3s23c, r_c23c;
    t_wide r_px, r_py, r_pz, r_cs[NumJ], r_cc[NumJ];
    always_ff @(posedge i_clk) begin
        r_A <= mulq(r_bc[3], r_bs[0]) - mulq(r_bs[3], r_u);
        r_B <= mulq(r_bs[0], r_bs[3]) + mulq(r_bc[3], r_u);
        r_C <= mulq(r_bc[0], r_bc[3]) + mulq(r_bs[3], r_v);
        r_D <= mulq(r_bc[0], r_bs[3]) - mulq(r_bc[3], r_v);
        r_F <= mulq(r_bs[4], r_bc23) + mulq(r_c3c4, r_bs23);
        r_G <= r_g;
        r_cs23c <= r_cs23;
        r_ss23c <= r_ss23;
        r_c3s23c <= r_c3s23;
        r_c23c <= r_bc23;
        r_px <= clampv(mulq(r_reach, r_bc[0]), PosLim);
        r_py <= clampv(mulq(r_reach, r_bs[0]), PosLim);
        r_pz <= clampv(r_z, PosLim);
        for (int i = 0; i < NumJ; i++) begin
            r_cs[i] <= r_bs[i];
            r_cc[i] <= r_bc[i];
        end
    end

    // stage D
    t_wide r_dA, r_dC, r_dE, r_dF, r_dG, r_dH, r_r6, r_r7, r_r8;
    t_wide r_dpx, r_dpy, r_dpz, r_s5, r_c5;
    always_ff @(posedge i_clk) begin
        r_dE <= mulq(r_cc[4], r_D) + mulq(r_cs[4], r_ss23c);
        r_dH <= mulq(r_cc[4], r_B) - mulq(r_cs[4], r_cs23c);
        r_r6 <= clampv(-mulq(r_cs[4], r_B) - mulq(r_cc[4], r_cs23c), RotLim);
        r_r7 <= clampv(mulq(r_cs[4], r_D) - mulq(r_cc[4], r_ss23c), RotLim);
        r_r8 <= clampv(mulq(r_cs[4], r_c3s23c) - mulq(r_cc[4], r_c23c), RotLim);
        r_dA <= r_A; r_dC <= r_C; r_dF <= r_F; r_dG <= r_G;
        r_dpx <= r_px; r_dpy <= r_py; r_dpz <= r_pz;
        r_s5 <= r_cs[5]; r_c5 <= r_cc[5];
    end

    // stage E: final wrist roll
    always_ff @(posedge i_clk) begin
        o_res[0] <= OutW'(clampv(mulq(r_s5, r_dA) + mulq(r_c5, r_dH), RotLim));
        o_res[1] <= OutW'(clampv(-mulq(r_s5, r_dC) - mulq(r_c5, r_dE), RotLim));
        o_res[2] <= OutW'(clampv(mulq(r_s5, r_dG) - mulq(r_c5, r_dF), RotLim));
        o_res[3] <= OutW'(clampv(mulq(r_c5, r_dA) - mulq(r_s5, r_dH), RotLim));
        o_res[4] <= OutW'(clampv(mulq(r_s5, r_dE) - mulq(r_c5, r_dC), RotLim));
        o_res[5] <= OutW'(clampv(mulq(r_s5, r_dF) + mulq(r_c5, r_dG), RotLim));
        o_res[6] <= OutW'(r_r6);
        o_res[7] <= OutW'(r_r7);
        o_res[8] <= OutW'(r_r8);
        o_res[9] <= OutW'(r_dpx);
        o_res[10] <= OutW'(r_dpy);
        o_res[11] <= OutW'(r_dpz);
    end
endmodule

// ===== hdl/six_axis_forward_kinematics.sv =====
// Channel   | Direction | Handshake            | Payload
// command   | in        | i_start / o_busy     | i_joint1_deg .. i_joint6_deg
// result    | out       | o_done (one cycle)   | o_rot_00 .. o_rot_22, o_pos_x/y/z
// config    | in        | i_cfg_we, i_cfg_idx  | i_cfg_data
// One pose enters per cycle; o_busy stays low. Each result is taken after two
// scaling stages, seven two-stage series steps and an output register in each
// trig lane, plus five merge stages. Reset clears the valid pipe and reloads
// the link registers. The receiver cannot stall, so nothing is held back.
// Depends on safk_pkg, safk_trig_lane, safk_merge.
module six_axis_forward_kinematics (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    output logic                               o_busy,
    input  logic [safk_pkg::AngW-1:0]          i_joint1_deg,
    input  logic [safk_pkg::AngW-1:0]          i_joint2_deg,
    input  logic [safk_pkg::AngW-1:0]          i_joint3_deg,
    input  logic [safk_pkg::AngW-1:0]          i_joint4_deg,
    input  logic [safk_pkg::AngW-1:0]          i_joint5_deg,
    input  logic [safk_pkg::AngW-1:0]          i_joint6_deg,
    input  logic                               i_cfg_we,
    input  logic [2:0]                         i_cfg_idx,
    input  logic [safk_pkg::LenW-1:0]          i_cfg_data,
    output logic                               o_done,
    output logic [safk_pkg::OutW-1:0]          o_rot_00,
    output logic [safk_pkg::OutW-1:0]          o_rot_10,
    output logic [safk_pkg::OutW-1:0]          o_rot_20,
    output logic [safk_pkg::OutW-1:0]          o_rot_01,
    output logic [safk_pkg::OutW-1:0]          o_rot_11,
    output logic [safk_pkg::OutW-1:0]          o_rot_21,
    output logic [safk_pkg::OutW-1:0]          o_rot_02,
    output logic [safk_pkg::OutW-1:0]          o_rot_12,
    output logic [safk_pkg::OutW-1:0]          o_rot_22,
    output logic [safk_pkg::OutW-1:0]          o_pos_x,
    output logic [safk_pkg::OutW-1:0]          o_pos_y,
    output logic [safk_pkg::OutW-1:0]          o_pos_z
);
    import safk_pkg::*;

    localparam int Lat = 2 + 2 * CosSteps + 1 + 5;

    logic signed [LenW-1:0] r_a1, r_a2, r_a3, r_d4, r_d1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a1 <= 30'sd17039360;
            r_a2 <= 30'sd44564480;
            r_a3 <= 30'sd2293760;
            r_d4 <= -30'sd43909120;
            r_d1 <= 30'sd44236800;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                RegA1: r_a1 <= i_cfg_data;
                RegA2: r_a2 <= i_cfg_data;
                RegA3: r_a3 <= i_cfg_data;
                RegD4: r_d4 <= i_cfg_data;
                RegD1: r_d1 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic [AngW-1:0] ang [NumJ];
    assign ang[0] = i_joint1_deg;
    assign ang[1] = i_joint2_deg;
    assign ang[2] = i_joint3_deg;
    assign ang[3] = i_joint4_deg;
    assign ang[4] = i_joint5_deg;
    assign ang[5] = i_joint6_deg;

    t_sc sc [NumJ];
    for (genvar j = 0; j < NumJ; j++) begin : g_lane
        safk_trig_lane u_lane (.i_clk(i_clk), .i_angle(ang[j]), .o_sc(sc[j]));
    end

    logic signed [OutW-1:0] res [12];
    safk_merge u_merge (
        .i_clk(i_clk), .i_sc(sc),
        .i_a1(r_a1), .i_a2(r_a2), .i_a3(r_a3), .i_d4(r_d4), .i_d1(r_d1),
        .o_res(res)
    );

    // track which pipeline slots carry a word
    logic [Lat-1:0] r_vld;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= '0;
        else r_vld <= {r_vld[Lat-2:0], i_start};
    end

    assign o_busy = 1'b0;
    assign o_done = r_vld[Lat-1];
    assign o_rot_00 = res[0];
    assign o_rot_10 = res[1];
    assign o_rot_20 = res[2];
    assign o_rot_01 = res[3];
    assign o_rot_11 = res[4];
    assign o_rot_21 = res[5];
    assign o_rot_02 = res[6];
    assign o_rot_12 = res[7];
    assign o_rot_22 = res[8];
    assign o_pos_x = res[9];
    assign o_pos_y = res[10];
    assign o_pos_z = res[11];
endmodule

// ===== hdl/safk_checker.sv =====
// Port-level checks for six_axis_forward_kinematics, bound to the top level.
// Depends on safk_pkg.
module safk_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_start,
    input logic                          o_busy,
    input logic                          o_done,
    input logic [safk_pkg::OutW-1:0]     o_rot_00,
    input logic [safk_pkg::OutW-1:0]     o_pos_z
);
    import safk_pkg::*;

    a_no_busy: assert property (@(posedge i_clk) o_busy == 1'b0)
        else $error("busy raised");
    a_done_reset: assert property (@(posedge i_clk) !i_rst_n |=> !o_done)
        else $error("done after reset");
    a_done_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(i_start, 22))
        else $error("done without start");
    a_rot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ($signed(o_rot_00) <= 32'sd1073741824 &&
                    $signed(o_rot_00) >= -32'sd1073741824))
        else $error("rotation out of range");
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ($signed(o_pos_z) <= 32'sd1342177280 &&
                    $signed(o_pos_z) >= -32'sd1342177280))
        else $error("position out of range");
endmodule

bind six_axis_forward_kinematics safk_checker u_safk_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
    .o_done(o_done), .o_rot_00(o_rot_00), .o_pos_z(o_pos_z)
);

// ===== tb/tb_six_axis_forward_kinematics.sv =====
// Self-checking testbench for six_axis_forward_kinematics: directed poses, then random poses
// under several link settings, each result checked against an in-bench fixed-point predictor or a known pose.
// Depends on safk_pkg and the six_axis_forward_kinematics RTL.
module tb_six_axis_forward_kinematics;
    import safk_pkg::*;

    localparam longint Deg360L = 23592960;
    localparam longint Deg90L  = 5898240;
    localparam longint Deg45L  = 2949120;
    localparam longint unsigned RadQ40 = 64'd19190098069;
    localparam longint unsigned OneQ32 = 64'h1_0000_0000;
    localparam longint RotMax = 1073741824;
    localparam longint PosMax = 1342177280;
    localparam logic [2:0] RegSpare = 3'd5;
    localparam logic [2:0] RegTop   = 3'd7;
    localparam int unsigned CycleLimit = 400000;
    localparam int Latency = 22;
    localparam int PhaseItems = 225;

    typedef logic [5:0][AngW-1:0] t_joints;
    typedef logic [11:0][OutW-1:0] t_pose;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_start = 1'b0;
    logic o_busy;
    logic [AngW-1:0] i_j1 = '0, i_j2 = '0, i_j3 = '0, i_j4 = '0, i_j5 = '0, i_j6 = '0;
    logic i_cfg_we = 1'b0;
    logic [2:0] i_cfg_idx = '0;
    logic [LenW-1:0] i_cfg_data = '0;
    logic o_done;
    t_pose got;

    six_axis_forward_kinematics u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
        .i_joint1_deg(i_j1), .i_joint2_deg(i_j2), .i_joint3_deg(i_j3),
        .i_joint4_deg(i_j4), .i_joint5_deg(i_j5), .i_joint6_deg(i_j6),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .o_done(o_done),
        .o_rot_00(got[0]), .o_rot_10(got[1]), .o_rot_20(got[2]),
        .o_rot_01(got[3]), .o_rot_11(got[4]), .o_rot_21(got[5]),
        .o_rot_02(got[6]), .o_rot_12(got[7]), .o_rot_22(got[8]),
        .o_pos_x(got[9]), .o_pos_y(got[10]), .o_pos_z(got[11])
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // link lengths as the block should hold them
    longint len_a1 = 17039360, len_a2 = 44564480, len_a3 = 2293760;
    longint len_d4 = -43909120, len_d1 = 44236800;

    t_pose pose_queue[$];
    int mismatches = 0;
    int poses_checked = 0;
    int unsigned cycles = 0;
    string field_name[12] = '{"rot_00", "rot_10", "rot_20", "rot_01", "rot_11", "rot_21",
                              "rot_02", "rot_12", "rot_22", "pos_x", "pos_y", "pos_z"};

    function automatic longint qmul(input longint a, input longint b);
        longint p;
        longint unsigned m;
        p = a * b;
        m = p < 0 ? longint'(-p) : p;
        m = (m + (64'd1 << 29)) >> 30;
        return p < 0 ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint sat(input longint v, input longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    function automatic void joint_sincos(input logic [AngW-1:0] raw,
                                         output longint sn, output longint cs);
        int unsigned sin_n[6] = '{156, 110, 72, 42, 20, 6};
        int unsigned cos_n[7] = '{182, 132, 90, 56, 30, 12, 2};
        longint a, s0, c0, k;
        longint unsigned r, x, x2, t, sv, cv;
        int q;
        bit swapped;
        a = longint'($signed(raw)) % Deg360L;
        if (a < 0) a += Deg360L;
        q = int'(a / Deg90L);
        r = a - longint'(q) * Deg90L;
        swapped = 1'b0;
        if (r > Deg45L) begin
            r = Deg90L - r;
            swapped = 1'b1;
        end
        x = (r * RadQ40 + (64'd1 << 23)) >> 24;
        x2 = (x * x) >> 32;
        t = OneQ32;
        for (int i = 0; i < 6; i++) t = OneQ32 - ((x2 * t) >> 32) / sin_n[i];
        sv = (x * t) >> 32;
        t = OneQ32;
        for (int i = 0; i < 7; i++) t = OneQ32 - ((x2 * t) >> 32) / cos_n[i];
        cv = t;
        s0 = longint'((sv + 2) >> 2);
        c0 = longint'((cv + 2) >> 2);
        if (swapped) begin
            k = s0; s0 = c0; c0 = k;
        end
        case (q & 3)
            0: begin sn = s0;  cs = c0;  end
            1: begin sn = c0;  cs = -s0; end
            2: begin sn = -s0; cs = -c0; end
            default: begin sn = -c0; cs = s0; end
        endcase
    endfunction

    function automatic t_pose arm_pose(input t_joints j);
        longint s[6], c[6], r[12];
        longint c23, s23, u, v, cs23, ss23, pa, pb, pc, pd, pe, pf, pg, ph, reach;
        t_pose p;
        for (int i = 0; i < 6; i++) joint_sincos(j[i], s[i], c[i]);
        c23 = qmul(c[1], c[2]) - qmul(s[1], s[2]);
        s23 = qmul(c[1], s[2]) + qmul(s[1], c[2]);
        u = qmul(c[0], c23);
        v = qmul(s[0], c23);
        cs23 = qmul(c[0], s23);
        ss23 = qmul(s[0], s23);
        pa = qmul(c[3], s[0]) - qmul(s[3], u);
        pb = qmul(s[0], s[3]) + qmul(c[3], u);
        pc = qmul(c[0], c[3]) + qmul(s[3], v);
        pd = qmul(c[0], s[3]) - qmul(c[3], v);
        pe = qmul(c[4], pd) + qmul(s[4], ss23);
        pf = qmul(s[4], c23) + qmul(qmul(c[3], c[4]), s23);
        pg = qmul(s[3], s23);
        ph = qmul(c[4], pb) - qmul(s[4], cs23);
        r[0] = qmul(s[5], pa) + qmul(c[5], ph);
        r[1] = -qmul(s[5], pc) - qmul(c[5], pe);
        r[2] = qmul(s[5], pg) - qmul(c[5], pf);
        r[3] = qmul(c[5], pa) - qmul(s[5], ph);
        r[4] = qmul(s[5], pe) - qmul(c[5], pc);
        r[5] = qmul(s[5], pf) + qmul(c[5], pg);
        r[6] = -qmul(s[4], pb) - qmul(c[4], cs23);
        r[7] = qmul(s[4], pd) - qmul(c[4], ss23);
        r[8] = qmul(s[4], qmul(c[3], s23)) - qmul(c[4], c23);
        for (int i = 0; i < 9; i++) r[i] = sat(r[i], RotMax);
        reach = len_a1 + qmul(len_a2, c[1]) + qmul(len_a3, c23) - qmul(len_d4, s23);
        r[9] = sat(qmul(reach, c[0]), PosMax);
        r[10] = sat(qmul(reach, s[0]), PosMax);
        r[11] = sat(len_d1 - qmul(len_d4, c23) - qmul(len_a2, s[1]) - qmul(len_a3, s23),
                    PosMax);
        for (int i = 0; i < 12; i++) p[i] = r[i][OutW-1:0];
        return p;
    endfunction

    // check each word on the done strobe against the oldest expectation
    always @(posedge i_clk) begin
        t_pose want;
        if (i_rst_n && o_done) begin
            if (pose_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result word: %h", got);
            end else begin
                want = pose_queue.pop_front();
                poses_checked++;
                for (int i = 0; i < 12; i++) begin
                    if (got[i] !== want[i]) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch %s: expected %h got %h", field_name[i],
                                     want[i], got[i]);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic logic [AngW-1:0] deg(input int d);
        return AngW'(longint'(d) * 65536);
    endfunction

    function automatic logic [AngW-1:0] random_angle();
        case ($urandom_range(9))
            0: return AngW'($urandom);
            1: return deg(90 * $urandom_range(8)) + AngW'($urandom_range(4)) - AngW'(2);
            default: return AngW'(longint'($urandom_range(47185920)) - Deg360L);
        endcase
    endfunction

    task automatic send_pose(input t_joints j, input int idle_pct, input bit typed,
                             input t_pose typed_pose);
        while ($urandom_range(99) < idle_pct) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
        i_start <= 1'b1;
        {i_j6, i_j5, i_j4, i_j3, i_j2, i_j1} <= j;
        do @(posedge i_clk); while (o_busy);
        pose_queue = {pose_queue, (typed ? typed_pose : arm_pose(j))};
    endtask

    // hold off until the pipe drains, then load registers
    task automatic drain();
        i_start <= 1'b0;
        while (pose_queue.size() != 0) @(posedge i_clk);
        repeat (Latency + 4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [LenW-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            RegA1: len_a1 = longint'($signed(data));
            RegA2: len_a2 = longint'($signed(data));
            RegA3: len_a3 = longint'($signed(data));
            RegD4: len_d4 = longint'($signed(data));
            RegD1: len_d1 = longint'($signed(data));
            default: ;
        endcase
    endtask

    task automatic load_links(input logic [LenW-1:0] a1, a2, a3, d4, d1);
        write_reg(RegA1, a1);
        write_reg(RegA2, a2);
        write_reg(RegA3, a3);
        write_reg(RegD4, d4);
        write_reg(RegD1, d1);
        // writes to unused indexes must be dropped
        write_reg(RegSpare, LenW'($urandom));
        write_reg(RegTop, LenW'($urandom));
    endtask

    t_joints dir_joints[$];
    bit dir_typed[$];
    t_pose home_pose;

    task automatic add_row(input int d1, d2, d3, d4, d5, d6, input bit typed);
        dir_joints = {dir_joints, {deg(d6), deg(d5), deg(d4), deg(d3), deg(d2), deg(d1)}};
        dir_typed = {dir_typed, typed};
    endtask

    initial begin
        t_joints j;
        int idle_pct;
        int items;
        home_pose = '0;
        home_pose[0] = 32'h4000_0000;
        home_pose[4] = 32'hC000_0000;
        home_pose[8] = 32'hC000_0000;
        home_pose[9] = 32'd63897600;
        home_pose[11] = 32'd88145920;

        // zero pose and its full-turn aliases have a known result
        add_row(0, 0, 0, 0, 0, 0, 1'b1);
        add_row(360, -360, 360, -360, 360, -360, 1'b1);
        add_row(-360, 360, 0, 360, 0, 360, 1'b1);
        add_row(90, 90, 90, 90, 90, 90, 1'b0);
        add_row(180, 180, 180, 180, 180, 180, 1'b0);
        add_row(270, -90, -270, 270, -90, 90, 1'b0);
        add_row(45, 45, 45, 45, 45, 45, 1'b0);
        add_row(-45, 135, 225, 315, -135, -225, 1'b0);
        add_row(359, -359, 1, -1, 179, -179, 1'b0);
        add_row(30, 60, -30, -60, 120, -120, 1'b0);
        add_row(0, 90, -90, 0, 90, 0, 1'b0);
        add_row(10, -20, 30, -40, 50, -60, 1'b0);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < dir_joints.size(); k++)
            send_pose(dir_joints[k], 0, dir_typed[k], home_pose);
        // field extremes: most positive and most negative raw codes
        send_pose({6{26'h1FF_FFFF}}, 0, 1'b0, home_pose);
        send_pose({6{26'h200_0000}}, 0, 1'b0, home_pose);
        send_pose({3{26'h1FF_FFFF, 26'h200_0000}}, 0, 1'b0, home_pose);
        drain();

        items = 0;
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: ;
                1: load_links(30'h1FFF_FFFF, 30'h1FFF_FFFF, 30'h1FFF_FFFF, 30'h1FFF_FFFF,
                              30'h1FFF_FFFF);
                2: load_links(30'h2000_0000, 30'h2000_0000, 30'h2000_0000, 30'h2000_0000,
                              30'h2000_0000);
                3: load_links('0, '0, '0, '0, '0);
                4: load_links(30'(268435456), 30'(-268435456), 30'(268435456),
                              30'(-268435456), 30'(268435456));
                default: load_links(LenW'($urandom), LenW'($urandom), LenW'($urandom),
                                    LenW'($urandom), LenW'($urandom));
            endcase
            for (int n = 0; n < PhaseItems; n++) begin
                idle_pct = items < 450 ? 18 : (items < 900 ? 58 : 0);
                // a few back-to-back bursts even in the idling stretches
                if ((n % 40) >= 32) idle_pct = 0;
                for (int a = 0; a < 6; a++) j[a] = random_angle();
                send_pose(j, idle_pct, 1'b0, home_pose);
                items++;
            end
            drain();
        end

        $display("checked %0d poses over 6 link settings, %0d mismatching fields",
                 poses_checked, mismatches);
        if (mismatches == 0 && pose_queue.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== six_axis_forward_kinematics.f =====
hdl/safk_pkg.sv
hdl/safk_trig_lane.sv
hdl/safk_merge.sv
hdl/six_axis_forward_kinematics.sv
hdl/safk_checker.sv
tb/tb_six_axis_forward_kinematics.sv
